// ----- src/tlpt_pkg.sv -----
// Package for the two-level page table core: sizes, entry layouts and codes.
// Used by the core, the checker and the testbench; depends on nothing.
`default_nettype none
package tlpt_pkg;

  localparam int unsigned DIR_ENTRIES   = 1024;
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned POOL_TABLES   = 16;
  localparam int unsigned FRAME_BITS    = 20;

  localparam int unsigned DIR_SHIFT  = 22;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam int unsigned IDX_W       = $clog2(TABLE_ENTRIES);
  localparam int unsigned DIR_IDX_W   = $clog2(DIR_ENTRIES);
  localparam int unsigned SLOT_W      = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned FREE_W      = $clog2(POOL_TABLES + 1);
  localparam int unsigned POOL_ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned POOL_DEPTH  = POOL_TABLES * TABLE_ENTRIES;

  typedef enum logic [1:0] {
    MODE_MAP   = 2'd0,
    MODE_UNMAP = 2'd1,
    MODE_XLATE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // Directory entry: present, user and the pool slot of its page table.
  typedef struct packed {
    logic              present;
    logic              user;
    logic [SLOT_W-1:0] slot;
  } dir_entry_t;

  // Page table entry: user, writable, present and the physical frame.
  typedef struct packed {
    logic                  user;
    logic                  rw;
    logic                  present;
    logic [FRAME_BITS-1:0] frame;
  } pte_t;

  localparam int unsigned DIR_W = $bits(dir_entry_t);
  localparam int unsigned PTE_W = $bits(pte_t);

endpackage
`default_nettype wire

// ----- src/tlpt_req_if.sv -----
// Request channel of the page table core: valid/ready and one operation.
// Depends on nothing.
`default_nettype none
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] virtual_address;
  logic [31:0] physical_address;
  logic [1:0]  map_flags;

  modport source (output valid, mode, virtual_address, physical_address, map_flags,
                  input ready);
  modport sink   (input valid, mode, virtual_address, physical_address, map_flags,
                  output ready);
endinterface
`default_nettype wire

// ----- src/tlpt_rsp_if.sv -----
// Response channel of the page table core: valid/ready and one result.
// Depends on nothing.
`default_nettype none
interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] translated_address;
  logic [1:0]  status;

  modport source (output valid, translated_address, status, input ready);
  modport sink   (input valid, translated_address, status, output ready);
endinterface
`default_nettype wire

// ----- src/tlpt_ram.sv -----
// Generic simple dual-port synchronous RAM: one write and one registered read port.
// Depends on nothing.
`default_nettype none
module tlpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- src/two_level_page_table_core.sv -----
// Two-level page table core: directory memory, table pool memory and sequencer.
// Depends on tlpt_pkg, tlpt_req_if, tlpt_rsp_if and tlpt_ram.
//
// Usage. Requests arrive on req_i (map, unmap, translate or no operation) and
// each one gives exactly one result on rsp_o. A transfer takes place on a
// rising edge with valid and ready both high. One request is worked on at a
// time; req_i.ready is high only while the sequencer is waiting for work.
// Steps per request, from its accepting edge until the sequencer is free
// again:
//   map to a present directory entry, unmap or translate of an absent one,
//   no operation, or a map that finds the pool exhausted: the directory read;
//   unmap or translate through a present directory entry: the directory read
//   and then the page table read, as the two reads follow one another;
//   map that allocates a new table: the directory read, then the sweep that
//   clears the new table one entry per cycle through the pool write port, then the result step.
// The result is loaded into the output register at the same edge at which
// the sequencer is free again and is on rsp_o from that edge on. It is held
// there while the receiver stalls; the next request is accepted meanwhile,
// and the sequencer waits at its last step only if the earlier result has
// still not been taken.
// After reset a pass writes the directory (entry 0 present, slot 0, all
// others clear) and the identity map of pool table 0; no request is accepted
// until that pass is over.
`default_nettype none
module two_level_page_table_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tlpt_req_if.sink   req_i,
  tlpt_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_TAB,
    S_CLR,
    S_DONE
  } state_e;

  localparam logic [tlpt_pkg::IDX_W-1:0] LastIdx = tlpt_pkg::IDX_W'(tlpt_pkg::TABLE_ENTRIES - 1);
  localparam logic [tlpt_pkg::FREE_W-1:0] PoolLimit = tlpt_pkg::FREE_W'(tlpt_pkg::POOL_TABLES);

  state_e state_q, state_d;
  logic [tlpt_pkg::IDX_W-1:0]         cnt_q, cnt_d;
  logic [tlpt_pkg::FREE_W-1:0]        next_free_q, next_free_d;
  tlpt_pkg::mode_e                    mode_q, mode_d;
  logic [tlpt_pkg::DIR_IDX_W-1:0]     di_q, di_d;
  logic [tlpt_pkg::IDX_W-1:0]         ti_q, ti_d;
  logic [tlpt_pkg::PAGE_SHIFT-1:0]    off_q, off_d;
  logic [tlpt_pkg::FRAME_BITS-1:0]    frame_q, frame_d;
  logic [1:0]                         flags_q, flags_d;
  logic [tlpt_pkg::SLOT_W-1:0]        slot_q, slot_d;
  logic                               rsp_valid_q, rsp_valid_d;
  logic [31:0]                        rsp_addr_q, rsp_addr_d;
  tlpt_pkg::status_e                  rsp_status_q, rsp_status_d;

  // Memory ports.
  logic                               dir_we;
  logic [tlpt_pkg::DIR_IDX_W-1:0]     dir_waddr, dir_raddr;
  tlpt_pkg::dir_entry_t               dir_wdata, dir_rdata;
  logic                               pool_we;
  logic [tlpt_pkg::POOL_ADDR_W-1:0]   pool_waddr, pool_raddr;
  tlpt_pkg::pte_t                     pool_wdata, pool_rdata;

  logic                               out_free;
  tlpt_pkg::pte_t                     map_pte;
  tlpt_pkg::pte_t                     ident_pte;
  tlpt_pkg::dir_entry_t               root_dent;

  tlpt_ram #(
    .WIDTH (tlpt_pkg::DIR_W),
    .DEPTH (tlpt_pkg::DIR_ENTRIES),
    .ADDR_W(tlpt_pkg::DIR_IDX_W)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (dir_we),
    .waddr_i(dir_waddr),
    .wdata_i(dir_wdata),
    .raddr_i(dir_raddr),
    .rdata_o(dir_rdata)
  );

  tlpt_ram #(
    .WIDTH (tlpt_pkg::PTE_W),
    .DEPTH (tlpt_pkg::POOL_DEPTH),
    .ADDR_W(tlpt_pkg::POOL_ADDR_W)
  ) u_pool_ram (
    .clk_i  (clk_i),
    .we_i   (pool_we),
    .waddr_i(pool_waddr),
    .wdata_i(pool_wdata),
    .raddr_i(pool_raddr),
    .rdata_o(pool_rdata)
  );

  // The page table entry that a map writes.
  always_comb begin
    map_pte.user    = flags_q[1];
    map_pte.rw      = flags_q[0];
    map_pte.present = 1'b1;
    map_pte.frame   = frame_q;
  end

  // Identity map of pool table 0: page i points to frame i, writable, kernel.
  always_comb begin
    ident_pte.user    = 1'b0;
    ident_pte.rw      = 1'b1;
    ident_pte.present = 1'b1;
    ident_pte.frame   = {{(tlpt_pkg::FRAME_BITS - tlpt_pkg::IDX_W){1'b0}}, cnt_q};
  end

  always_comb begin
    root_dent.present = 1'b1;
    root_dent.user    = 1'b0;
    root_dent.slot    = '0;
  end

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    next_free_d  = next_free_q;
    mode_d       = mode_q;
    di_d         = di_q;
    ti_d         = ti_q;
    off_d        = off_q;
    frame_d      = frame_q;
    flags_d      = flags_q;
    slot_d       = slot_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_addr_d   = rsp_addr_q;
    rsp_status_d = rsp_status_q;

    dir_we     = 1'b0;
    dir_waddr  = di_q;
    dir_wdata  = '0;
    dir_raddr  = di_q;
    pool_we    = 1'b0;
    pool_waddr = {slot_q, ti_q};
    pool_wdata = '0;
    pool_raddr = {slot_q, ti_q};

    case (state_q)
      S_INIT: begin
        // Reset pass: directory entry i and pool table 0 entry i per cycle.
        dir_we     = 1'b1;
        dir_waddr  = tlpt_pkg::DIR_IDX_W'(cnt_q);
        dir_wdata  = (cnt_q == '0) ? root_dent : '0;
        pool_we    = 1'b1;
        pool_waddr = {{tlpt_pkg::SLOT_W{1'b0}}, cnt_q};
        pool_wdata = ident_pte;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        dir_raddr = req_i.virtual_address[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::DIR_IDX_W];
        if (req_i.valid) begin
          mode_d  = tlpt_pkg::mode_e'(req_i.mode);
          di_d    = req_i.virtual_address[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::DIR_IDX_W];
          ti_d    = req_i.virtual_address[tlpt_pkg::PAGE_SHIFT +: tlpt_pkg::IDX_W];
          off_d   = req_i.virtual_address[tlpt_pkg::PAGE_SHIFT-1:0];
          frame_d = req_i.physical_address[tlpt_pkg::PAGE_SHIFT +: tlpt_pkg::FRAME_BITS];
          flags_d = req_i.map_flags;
          state_d = S_DIR;
        end
      end

      S_DIR: begin
        // Directory data for di_q is on the read port now.
        case (mode_q)
          tlpt_pkg::MODE_MAP: begin
            if (!dir_rdata.present) begin
              if (next_free_q >= PoolLimit) begin
                if (out_free) begin
                  rsp_valid_d  = 1'b1;
                  rsp_addr_d   = '0;
                  rsp_status_d = tlpt_pkg::STATUS_FULL;
                  state_d      = S_IDLE;
                end
              end else begin
                // Take the next table from the pool and link it in.
                slot_d            = next_free_q[tlpt_pkg::SLOT_W-1:0];
                next_free_d       = next_free_q + 1'b1;
                dir_we            = 1'b1;
                dir_wdata.present = 1'b1;
                dir_wdata.user    = flags_q[1];
                dir_wdata.slot    = next_free_q[tlpt_pkg::SLOT_W-1:0];
                cnt_d             = '0;
                state_d           = S_CLR;
              end
            end else if (out_free) begin
              pool_we      = 1'b1;
              pool_waddr   = {dir_rdata.slot, ti_q};
              pool_wdata   = map_pte;
              rsp_valid_d  = 1'b1;
              rsp_addr_d   = '0;
              rsp_status_d = tlpt_pkg::STATUS_DONE;
              state_d      = S_IDLE;
            end
          end

          tlpt_pkg::MODE_UNMAP, tlpt_pkg::MODE_XLATE: begin
            if (!dir_rdata.present) begin
              if (out_free) begin
                rsp_valid_d  = 1'b1;
                rsp_addr_d   = '0;
                rsp_status_d = tlpt_pkg::STATUS_MISS;
                state_d      = S_IDLE;
              end
            end else begin
              slot_d     = dir_rdata.slot;
              pool_raddr = {dir_rdata.slot, ti_q};
              state_d    = S_TAB;
            end
          end

          default: begin
            if (out_free) begin
              rsp_valid_d  = 1'b1;
              rsp_addr_d   = '0;
              rsp_status_d = tlpt_pkg::STATUS_DONE;
              state_d      = S_IDLE;
            end
          end
        endcase
      end

      S_TAB: begin
        // Page table entry is on the pool read port; it holds while we wait.
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = pool_rdata.present ? tlpt_pkg::STATUS_DONE : tlpt_pkg::STATUS_MISS;
          if (mode_q == tlpt_pkg::MODE_UNMAP) begin
            pool_we            = 1'b1;
            pool_wdata         = pool_rdata;
            pool_wdata.present = 1'b0;
            rsp_addr_d         = '0;
          end else begin
            rsp_addr_d = pool_rdata.present ? {pool_rdata.frame, off_q} : '0;
          end
          state_d = S_IDLE;
        end
      end

      S_CLR: begin
        // Clear the new table, writing the mapped entry at its own index.
        pool_we    = 1'b1;
        pool_waddr = {slot_q, cnt_q};
        pool_wdata = (cnt_q == ti_q) ? map_pte : '0;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_addr_d   = '0;
          rsp_status_d = tlpt_pkg::STATUS_DONE;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      next_free_q  <= tlpt_pkg::FREE_W'(1);
      mode_q       <= tlpt_pkg::MODE_NOP;
      di_q         <= '0;
      ti_q         <= '0;
      off_q        <= '0;
      frame_q      <= '0;
      flags_q      <= '0;
      slot_q       <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_addr_q   <= '0;
      rsp_status_q <= tlpt_pkg::STATUS_DONE;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      next_free_q  <= next_free_d;
      mode_q       <= mode_d;
      di_q         <= di_d;
      ti_q         <= ti_d;
      off_q        <= off_d;
      frame_q      <= frame_d;
      flags_q      <= flags_d;
      slot_q       <= slot_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_addr_q   <= rsp_addr_d;
      rsp_status_q <= rsp_status_d;
    end
  end

  assign req_i.ready              = (state_q == S_IDLE);
  assign rsp_o.valid              = rsp_valid_q;
  assign rsp_o.translated_address = rsp_addr_q;
  assign rsp_o.status             = rsp_status_q;

endmodule
`default_nettype wire

// ----- bench/tlpt_checker.sv -----
// Checker for the two-level page table core: keeps its own copy of the directory
// and the table pool, works out one result per request transfer and compares it
// with each response transfer. Depends on tlpt_pkg, tlpt_req_if and tlpt_rsp_if.
`timescale 1ns / 100ps
module tlpt_checker
  import tlpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tlpt_req_if         req_i,
  tlpt_rsp_if         rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct {
    mode_e       op;
    logic [31:0] va;
    logic [31:0] addr;
    status_e     status;
  } page_result_t;

  dir_entry_t        dir_mirror  [DIR_ENTRIES];
  pte_t              pool_mirror [POOL_DEPTH];
  logic [FREE_W-1:0] free_slot;

  page_result_t page_results [$];
  int unsigned  mismatch_total = 0;

  assign errors_o = mismatch_total;

  // Applies one operation to the mirrored tables and returns the result it gives.
  function automatic page_result_t predict_page_op(input mode_e op, input logic [31:0] va,
                                                   input logic [31:0] pa,
                                                   input logic [1:0] flags);
    logic [DIR_IDX_W-1:0]   di;
    logic [IDX_W-1:0]       ti;
    logic [PAGE_SHIFT-1:0]  off;
    dir_entry_t             de;
    pte_t                   pte;
    page_result_t           res;
    di  = va[DIR_SHIFT +: DIR_IDX_W];
    ti  = va[PAGE_SHIFT +: IDX_W];
    off = va[PAGE_SHIFT-1:0];
    de  = dir_mirror[di];
    res.op     = op;
    res.va     = va;
    res.addr   = '0;
    res.status = STATUS_DONE;
    case (op)
      MODE_MAP: begin
        if (!de.present) begin
          if (free_slot >= POOL_TABLES) begin
            res.status = STATUS_FULL;
          end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
              pool_mirror[{free_slot[SLOT_W-1:0], IDX_W'(i)}] = '0;
            de.present = 1'b1;
            de.user    = flags[1];
            de.slot    = free_slot[SLOT_W-1:0];
            dir_mirror[di] = de;
            free_slot = free_slot + 1'b1;
          end
        end
        if (res.status == STATUS_DONE) begin
          pte.user    = flags[1];
          pte.rw      = flags[0];
          pte.present = 1'b1;
          pte.frame   = pa[PAGE_SHIFT +: FRAME_BITS];
          pool_mirror[{de.slot, ti}] = pte;
        end
      end
      MODE_UNMAP: begin
        if (!de.present) begin
          res.status = STATUS_MISS;
        end else begin
          if (!pool_mirror[{de.slot, ti}].present) res.status = STATUS_MISS;
          pool_mirror[{de.slot, ti}].present = 1'b0;
        end
      end
      MODE_XLATE: begin
        pte = pool_mirror[{de.slot, ti}];
        // Frame and offset fill the 32 bits exactly, so the sum is a concatenation.
        if (!de.present || !pte.present) res.status = STATUS_MISS;
        else res.addr = {pte.frame, off};
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    page_result_t want;
    if (!rst_ni) begin
      foreach (dir_mirror[i]) dir_mirror[i] = '0;
      foreach (pool_mirror[i]) pool_mirror[i] = '0;
      for (int p = 0; p < TABLE_ENTRIES; p++) begin
        pool_mirror[p].present = 1'b1;
        pool_mirror[p].rw      = 1'b1;
        pool_mirror[p].frame   = FRAME_BITS'(p);
      end
      dir_mirror[0].present = 1'b1;
      free_slot = 1;
      page_results.delete();
    end else begin
      // The response side goes first: a result never belongs to a request
      // accepted at the same edge.
      if (rsp_i.valid && rsp_i.ready) begin
        if (page_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: result with nothing outstanding: address %h status %0d",
                     $realtime, rsp_i.translated_address, rsp_i.status);
        end else begin
          want = page_results.pop_front();
          if (rsp_i.translated_address !== want.addr || rsp_i.status !== want.status) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("%0t: %s va %h: expected address %h status %s, got address %h status %0d",
                       $realtime, want.op.name(), want.va, want.addr, want.status.name(),
                       rsp_i.translated_address, rsp_i.status);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        page_results.push_back(predict_page_op(mode_e'(req_i.mode), req_i.virtual_address,
                                               req_i.physical_address, req_i.map_flags));
    end
    pending_o = page_results.size();
  end

endmodule

// ----- bench/tb_two_level_page_table_core.sv -----
// Top of the page table testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on tlpt_pkg, both channel interfaces,
// the core itself and tlpt_checker, which does all the prediction and comparison.
`timescale 1ns / 100ps
module tb_two_level_page_table_core;
  import tlpt_pkg::*;

  // Random part of the run; the last CALM_OPS of it run without any idling.
  localparam int unsigned RANDOM_OPS      = 430;
  localparam int unsigned CALM_OPS        = 60;
  // Length of the long response hold-off that fills the core and stalls requests.
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  // The slowest correct gap between two transfers is a table allocation
  // on top of a long hold-off; the limit is several times that.
  localparam int unsigned STALL_LIMIT     = 8000;
  // Cycles waited after the last expected result, so that a stray result is caught.
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned HOT_DIRS        = 24;
  localparam int unsigned HOT_PAGES       = 8;

  logic        clk_i;
  logic        rst_ni;
  int unsigned errors;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  // Shared between the request and response processes.
  bit calm_phase;
  bit hold_off_request;

  // Small sets of directory and table indices, so that maps, unmaps and
  // translations keep meeting each other on the same pages.
  logic [DIR_IDX_W-1:0] hot_dir  [HOT_DIRS];
  logic [IDX_W-1:0]     hot_page [HOT_PAGES];

  tlpt_req_if req_ch ();
  tlpt_rsp_if rsp_ch ();

  two_level_page_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  tlpt_checker walk_monitor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_i     (rsp_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offers one request from a falling edge and returns at the falling edge
  // after its transfer. Outside the calm phase a random idle burst may come
  // first, with valid low; otherwise valid simply stays high into the next item.
  task automatic offer_op(input mode_e op, input logic [31:0] va, input logic [31:0] pa,
                          input logic [1:0] flags);
    int unsigned gap;
    gap = 0;
    if (!calm_phase && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid            <= 1'b1;
    req_ch.mode             <= op;
    req_ch.virtual_address  <= va;
    req_ch.physical_address <= pa;
    req_ch.map_flags        <= flags;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Response side. Ready changes only on falling edges: random stall bursts,
  // longer stretches with ready high, the long hold-off when the request side
  // asks for it, and ready held high for the whole calm phase.
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_off_request && !calm_phase) begin
        hold_off_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        if (calm_phase) @(negedge clk_i);
        else repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_two_level_page_table_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    logic [31:0] va;
    mode_e       op;
    rst_ni                  = 1'b0;
    req_ch.valid            = 1'b0;
    req_ch.mode             = MODE_NOP;
    req_ch.virtual_address  = '0;
    req_ch.physical_address = '0;
    req_ch.map_flags        = '0;
    calm_phase              = 1'b0;
    hold_off_request        = 1'b0;

    // The first and last directory entries and pages are always in the hot sets.
    foreach (hot_dir[i]) hot_dir[i] = DIR_IDX_W'($urandom());
    hot_dir[0] = '0;
    hot_dir[1] = '1;
    hot_dir[2] = DIR_IDX_W'(1);
    hot_dir[3] = DIR_IDX_W'(DIR_ENTRIES / 2);
    foreach (hot_page[i]) hot_page[i] = IDX_W'($urandom());
    hot_page[0] = '0;
    hot_page[1] = '1;

    // The core runs its clearing pass after this and holds ready low until done.
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The reset identity map: frame 0 at offset 0 translates to
    // address 0 yet succeeds, and the top of the first 4 MB maps to itself.
    offer_op(MODE_XLATE, 32'h0000_0000, 32'h0000_0000, 2'd0);
    offer_op(MODE_XLATE, 32'h003F_FFFF, 32'h0000_0000, 2'd0);
    // Translate and unmap through an absent directory entry both miss.
    offer_op(MODE_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    offer_op(MODE_UNMAP, 32'hFFC0_0000, 32'h0000_0000, 2'd0);
    // A map into the last directory entry allocates a fresh table.
    offer_op(MODE_MAP,   32'hFFFF_F123, 32'hFFFF_FFFF, 2'd3);
    offer_op(MODE_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
    // The other entries of that fresh table must read as cleared.
    offer_op(MODE_XLATE, 32'hFFC0_0000, 32'h0000_0000, 2'd0);
    offer_op(MODE_UNMAP, 32'hFFC0_0000, 32'h0000_0000, 2'd0);
    // Overwrite an existing page with frame 0; low bits of the frame input are ignored.
    offer_op(MODE_MAP,   32'hFFFF_F000, 32'h0000_0ABC, 2'd0);
    offer_op(MODE_XLATE, 32'hFFFF_F000, 32'h0000_0000, 2'd0);
    // Unmap once succeeds, a second time misses, and the page stays absent.
    offer_op(MODE_UNMAP, 32'hFFFF_F000, 32'h0000_0000, 2'd0);
    offer_op(MODE_UNMAP, 32'hFFFF_F000, 32'h0000_0000, 2'd0);
    offer_op(MODE_XLATE, 32'hFFFF_F000, 32'h0000_0000, 2'd0);
    // Map through the existing reset directory entry, then translate with an offset.
    offer_op(MODE_MAP,   32'h0000_5000, 32'h1234_5FFF, 2'd1);
    offer_op(MODE_XLATE, 32'h0000_5ABC, 32'h0000_0000, 2'd0);
    // Unmapping part of the identity map.
    offer_op(MODE_UNMAP, 32'h0000_0000, 32'h0000_0000, 2'd0);
    offer_op(MODE_XLATE, 32'h0000_0123, 32'h0000_0000, 2'd0);
    // A user map into a new directory entry.
    offer_op(MODE_MAP,   32'h4000_0000, 32'h8000_0000, 2'd2);
    offer_op(MODE_XLATE, 32'h4000_0FFF, 32'h0000_0000, 2'd0);
    // No-operation with every field at both extremes.
    offer_op(MODE_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    offer_op(MODE_NOP,   32'h0000_0000, 32'h0000_0000, 2'd0);
    offer_op(MODE_MAP,   32'h0000_0000, 32'h0000_0000, 2'd0);

    // Random part. Most addresses land on the hot sets so that translations
    // and unmaps find real mappings; a quarter are fully random. Maps spread
    // over the hot directory entries use up the pool, after which maps to
    // absent entries report it as exhausted.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 100 || n == 250) hold_off_request = 1'b1;
      if (n == RANDOM_OPS - CALM_OPS) calm_phase = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = MODE_MAP;
      else if (pick < 55) op = MODE_UNMAP;
      else if (pick < 95) op = MODE_XLATE;
      else                op = MODE_NOP;
      va = $urandom();
      if ($urandom_range(0, 3) != 0) begin
        va[DIR_SHIFT +: DIR_IDX_W] = hot_dir[$urandom_range(0, HOT_DIRS - 1)];
        va[PAGE_SHIFT +: IDX_W]    = hot_page[$urandom_range(0, HOT_PAGES - 1)];
      end
      offer_op(op, va, $urandom(), 2'($urandom_range(0, 3)));
    end
    req_ch.valid <= 1'b0;

    // Wait for every outstanding result, then a little longer for strays;
    // the watchdog bounds both waits.
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_two_level_page_table_core OK");
    end else begin
      $display("tb_two_level_page_table_core NOT OK");
    end
    $finish;
  end

endmodule
